### design/tads_pkg.sv
`default_nettype none
package tads_pkg;

    localparam int CNT_W = 16;
    localparam int ACC_W = CNT_W + 1;
    localparam int POS_W = 24;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_ZSET = 2'd2,
        OP_HOME = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_HOME  = 2'd0,
        MODE_LOWER = 2'd1,
        MODE_CUT   = 2'd2,
        MODE_IDLE  = 2'd3
    } mode_t;

    typedef struct packed {
        op_t               op;
        mode_t             mode;
        logic              x_limit_open;
        logic              y_limit_open;
        logic              z_limit_open;
        logic              x_busy;
        logic              y_busy;
        logic [CNT_W-1:0]  x_steps;
        logic [CNT_W-1:0]  y_steps;
        logic [CNT_W-1:0]  tick_count;
        logic [1:0]        dirs;
        logic [CNT_W-1:0]  z_depth;
    } in_word_t;

    typedef struct packed {
        logic                    x_step;
        logic                    x_dir_level;
        logic                    y_step;
        logic                    y_dir_level;
        logic                    z_step;
        logic                    z_dir_level;
        logic signed [POS_W-1:0] x_coord;
        logic signed [POS_W-1:0] y_coord;
        logic [CNT_W-1:0]        z_coord;
        logic                    homed;
        logic                    segment_done;
    } out_word_t;

    typedef struct packed {
        logic              homed_flag;
        logic [ACC_W-1:0]  x_acc;
        logic [ACC_W-1:0]  y_acc;
        logic [POS_W-1:0]  x_pos;
        logic [POS_W-1:0]  y_pos;
        logic [CNT_W-1:0]  z_pos;
        logic [CNT_W-1:0]  seg_x_steps;
        logic [CNT_W-1:0]  seg_y_steps;
        logic [CNT_W-1:0]  seg_ticks;
        logic [1:0]        seg_dirs;
        logic              seg_done;
        logic [CNT_W-1:0]  ticks_left;
    } motion_state_t;

endpackage
`default_nettype wire

### design/tads_core.sv
`default_nettype none
module tads_core (
    input  wire tads_pkg::motion_state_t st,
    input  wire tads_pkg::in_word_t      word,
    output tads_pkg::motion_state_t      st_next,
    output tads_pkg::out_word_t          res
);

    logic [tads_pkg::ACC_W-1:0] x_sum;
    logic [tads_pkg::ACC_W-1:0] y_sum;
    logic [tads_pkg::ACC_W-1:0] ticks_ext;
    logic                       x_hit;
    logic                       y_hit;
    logic [tads_pkg::CNT_W-1:0] tl_start;
    logic [tads_pkg::CNT_W-1:0] tl_dec;
    logic                       xs;
    logic                       ys;
    logic                       zs;
    logic                       xd;
    logic                       yd;
    logic                       zd;

    assign ticks_ext = {1'b0, st.seg_ticks};
    assign x_sum     = st.x_acc + {1'b0, st.seg_x_steps};
    assign y_sum     = st.y_acc + {1'b0, st.seg_y_steps};
    assign x_hit     = (x_sum >= ticks_ext);
    assign y_hit     = (y_sum >= ticks_ext);
    assign tl_start  = (st.ticks_left == '0) ? st.seg_ticks : st.ticks_left;
    assign tl_dec    = tl_start - tads_pkg::CNT_W'(1);

    always_comb begin
        st_next = st;
        xs = 1'b0;
        ys = 1'b0;
        zs = 1'b0;
        xd = 1'b0;
        yd = 1'b0;
        zd = 1'b0;
        unique case (word.op)
            tads_pkg::OP_LOAD: begin
                st_next.seg_ticks   = word.tick_count;
                st_next.seg_x_steps = (word.x_steps > word.tick_count) ?
                                      word.tick_count : word.x_steps;
                st_next.seg_y_steps = (word.y_steps > word.tick_count) ?
                                      word.tick_count : word.y_steps;
                st_next.seg_dirs    = word.dirs;
                st_next.x_acc       = '0;
                st_next.y_acc       = '0;
                st_next.ticks_left  = '0;
                st_next.seg_done    = (word.tick_count == '0);
            end
            tads_pkg::OP_ZSET: begin
                st_next.z_pos = word.z_depth;
            end
            tads_pkg::OP_HOME: begin
                st_next.homed_flag = 1'b0;
            end
            tads_pkg::OP_TICK: begin
                if (word.mode != tads_pkg::MODE_CUT) begin
                    st_next.ticks_left = '0;
                end
                unique case (word.mode)
                    tads_pkg::MODE_HOME: begin
                        if (!st.homed_flag) begin
                            if (word.z_limit_open) begin
                                zs = 1'b1;
                                zd = 1'b1;
                            end else if (word.x_limit_open || word.y_limit_open) begin
                                xs = word.x_limit_open && !word.x_busy;
                                ys = word.y_limit_open && !word.y_busy;
                                yd = ys;
                            end else begin
                                // all limits closed: zero the machine
                                st_next.homed_flag  = 1'b1;
                                st_next.x_pos       = '0;
                                st_next.y_pos       = '0;
                                st_next.z_pos       = '0;
                                st_next.seg_x_steps = '0;
                                st_next.seg_y_steps = '0;
                                st_next.seg_ticks   = '0;
                                st_next.x_acc       = '0;
                                st_next.y_acc       = '0;
                                st_next.seg_done    = 1'b1;
                            end
                        end
                    end
                    tads_pkg::MODE_LOWER: begin
                        if (st.z_pos != '0) begin
                            zs = 1'b1;
                            st_next.z_pos = st.z_pos - tads_pkg::CNT_W'(1);
                        end
                    end
                    tads_pkg::MODE_CUT: begin
                        if (!st.seg_done && st.seg_ticks != '0) begin
                            if (x_hit) begin
                                xs = !word.x_busy;
                                xd = !word.x_busy && !st.seg_dirs[0];
                                st_next.x_pos = st.seg_dirs[0] ?
                                    st.x_pos - tads_pkg::POS_W'(1) :
                                    st.x_pos + tads_pkg::POS_W'(1);
                                st_next.x_acc = x_sum - ticks_ext;
                            end else begin
                                st_next.x_acc = x_sum;
                            end
                            if (y_hit) begin
                                ys = !word.y_busy;
                                yd = !word.y_busy && !st.seg_dirs[1];
                                st_next.y_pos = st.seg_dirs[1] ?
                                    st.y_pos + tads_pkg::POS_W'(1) :
                                    st.y_pos - tads_pkg::POS_W'(1);
                                st_next.y_acc = y_sum - ticks_ext;
                            end else begin
                                st_next.y_acc = y_sum;
                            end
                            st_next.ticks_left = tl_dec;
                            if (tl_dec == '0) begin
                                st_next.seg_done = 1'b1;
                            end
                        end
                    end
                    tads_pkg::MODE_IDLE: begin
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.x_step       = xs;
        res.x_dir_level  = xd;
        res.y_step       = ys;
        res.y_dir_level  = yd;
        res.z_step       = zs;
        res.z_dir_level  = zd;
        res.x_coord      = st_next.x_pos;
        res.y_coord      = st_next.y_pos;
        res.z_coord      = st_next.z_pos;
        res.homed        = st_next.homed_flag;
        res.segment_done = st_next.seg_done;
    end

endmodule
`default_nettype wire

### design/two_axis_dda_stepper_with_homing.sv
// Pipeline: input register, then result register. A word's result is written to the
// result register when the word advances; it waits while a held result is not taken.
// Throughput: one word per cycle unless m_ready stalls; set by the single-pass DDA
// update between the two registers, with motion state written on each advance.
// Reset: aresetn low at a rising edge empties both registers and returns the motion
// state to unhomed, zero positions and accumulators, no segment, both axes clockwise.
`default_nettype none
module two_axis_dda_stepper_with_homing (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire tads_pkg::in_word_t s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output tads_pkg::out_word_t  m_data
);

    tads_pkg::in_word_t       in_reg;
    logic                     in_valid_reg;
    tads_pkg::out_word_t      out_reg;
    logic                     out_valid_reg;
    tads_pkg::motion_state_t  st_reg;
    tads_pkg::motion_state_t  st_next;
    tads_pkg::out_word_t      res_next;
    logic                     advance;

    tads_core u_core (
        .st      (st_reg),
        .word    (in_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // move a word forward when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.homed_flag  <= 1'b0;
            st_reg.x_acc       <= '0;
            st_reg.y_acc       <= '0;
            st_reg.x_pos       <= '0;
            st_reg.y_pos       <= '0;
            st_reg.z_pos       <= '0;
            st_reg.seg_x_steps <= '0;
            st_reg.seg_y_steps <= '0;
            st_reg.seg_ticks   <= '0;
            st_reg.seg_dirs    <= 2'b11;
            st_reg.seg_done    <= 1'b1;
            st_reg.ticks_left  <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;
    import tads_pkg::*;

    localparam int RANDOM_WORDS = 600;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 64;
    localparam int HOLD_AT      = 250;

    typedef struct packed {
        in_word_t  stim;
        logic      fixed;
        out_word_t want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    motion_state_t motion;
    out_word_t     expected_words[$];
    stim_row_t     directed_rows[$];
    out_word_t     head_word;
    int unsigned   fail_count = 0;
    int unsigned   words_sent = 0;
    int unsigned   results_seen = 0;
    int unsigned   stall_cycles = 0;
    int            rx_hold = 0;
    bit            rx_burst = 0;
    bit            tx_burst = 0;

    two_axis_dda_stepper_with_homing dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Advance the motion state by one word and return the result it produces.
    function automatic out_word_t motion_predict(in_word_t w);
        out_word_t r;
        logic      x_cw;
        logic      y_cw;
        r = '0;
        x_cw = motion.seg_dirs[0];
        y_cw = motion.seg_dirs[1];
        case (w.op)
            OP_LOAD: begin
                motion.seg_ticks   = w.tick_count;
                motion.seg_x_steps = (w.x_steps > w.tick_count) ? w.tick_count : w.x_steps;
                motion.seg_y_steps = (w.y_steps > w.tick_count) ? w.tick_count : w.y_steps;
                motion.seg_dirs    = w.dirs;
                motion.x_acc       = '0;
                motion.y_acc       = '0;
                motion.ticks_left  = '0;
                motion.seg_done    = (w.tick_count == 0);
            end
            OP_ZSET: motion.z_pos = w.z_depth;
            OP_HOME: motion.homed_flag = 1'b0;
            OP_TICK: begin
                if (w.mode != MODE_CUT)
                    motion.ticks_left = '0;
                case (w.mode)
                    MODE_HOME: begin
                        if (!motion.homed_flag) begin
                            if (w.z_limit_open) begin
                                r.z_step      = 1'b1;
                                r.z_dir_level = 1'b1;
                            end else if (w.x_limit_open || w.y_limit_open) begin
                                // x homes clockwise (level 0), y counter-clockwise
                                r.x_step = w.x_limit_open && !w.x_busy;
                                if (w.y_limit_open && !w.y_busy) begin
                                    r.y_step      = 1'b1;
                                    r.y_dir_level = 1'b1;
                                end
                            end else begin
                                motion.homed_flag  = 1'b1;
                                motion.x_pos       = '0;
                                motion.y_pos       = '0;
                                motion.z_pos       = '0;
                                motion.seg_x_steps = '0;
                                motion.seg_y_steps = '0;
                                motion.seg_ticks   = '0;
                                motion.x_acc       = '0;
                                motion.y_acc       = '0;
                                motion.seg_done    = 1'b1;
                            end
                        end
                    end
                    MODE_LOWER: begin
                        if (motion.z_pos != 0) begin
                            r.z_step     = 1'b1;
                            motion.z_pos = motion.z_pos - 1'b1;
                        end
                    end
                    MODE_CUT: begin
                        if (!motion.seg_done && motion.seg_ticks != 0) begin
                            if (motion.ticks_left == 0)
                                motion.ticks_left = motion.seg_ticks;
                            motion.x_acc = motion.x_acc + motion.seg_x_steps;
                            if (motion.x_acc >= motion.seg_ticks) begin
                                // busy only hides the pulse; the axis still moves
                                if (!w.x_busy) begin
                                    r.x_step      = 1'b1;
                                    r.x_dir_level = !x_cw;
                                end
                                motion.x_pos = x_cw ? motion.x_pos - 1'b1 : motion.x_pos + 1'b1;
                                motion.x_acc = motion.x_acc - motion.seg_ticks;
                            end
                            motion.y_acc = motion.y_acc + motion.seg_y_steps;
                            if (motion.y_acc >= motion.seg_ticks) begin
                                if (!w.y_busy) begin
                                    r.y_step      = 1'b1;
                                    r.y_dir_level = !y_cw;
                                end
                                motion.y_pos = y_cw ? motion.y_pos + 1'b1 : motion.y_pos - 1'b1;
                                motion.y_acc = motion.y_acc - motion.seg_ticks;
                            end
                            motion.ticks_left = motion.ticks_left - 1'b1;
                            if (motion.ticks_left == 0)
                                motion.seg_done = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
        r.x_coord      = motion.x_pos;
        r.y_coord      = motion.y_pos;
        r.z_coord      = motion.z_pos;
        r.homed        = motion.homed_flag;
        r.segment_done = motion.seg_done;
        return r;
    endfunction

    function automatic in_word_t make_word(op_t op, mode_t mode, logic [2:0] open_xyz,
            logic [1:0] busy_xy, logic [CNT_W-1:0] xs, logic [CNT_W-1:0] ys,
            logic [CNT_W-1:0] tc, logic [1:0] dirs, logic [CNT_W-1:0] zd);
        in_word_t w;
        w = '0;
        w.op = op;
        w.mode = mode;
        {w.x_limit_open, w.y_limit_open, w.z_limit_open} = open_xyz;
        {w.x_busy, w.y_busy} = busy_xy;
        w.x_steps = xs;
        w.y_steps = ys;
        w.tick_count = tc;
        w.dirs = dirs;
        w.z_depth = zd;
        return w;
    endfunction

    // pulses: {x_step, x_dir, y_step, y_dir, z_step, z_dir}
    function automatic out_word_t fixed_out(logic [5:0] pulses, logic [POS_W-1:0] xp,
            logic [POS_W-1:0] yp, logic [CNT_W-1:0] zp, logic homed, logic done);
        return out_word_t'({pulses, xp, yp, zp, homed, done});
    endfunction

    function automatic in_word_t rand_word();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(in_word_t)-1:0];
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_word(in_word_t w, logic fixed, out_word_t want);
        int        gap;
        out_word_t predicted;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = motion_predict(w);
        expected_words.push_back(fixed ? want : predicted);
        words_sent++;
    endtask

    // Receiver: check each word, then hold ready low for a drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_data);
                    fail_count++;
                end else begin
                    head_word = expected_words.pop_front();
                    compare_field("x_step", head_word.x_step, m_data.x_step);
                    compare_field("x_dir_level", head_word.x_dir_level, m_data.x_dir_level);
                    compare_field("y_step", head_word.y_step, m_data.y_step);
                    compare_field("y_dir_level", head_word.y_dir_level, m_data.y_dir_level);
                    compare_field("z_step", head_word.z_step, m_data.z_step);
                    compare_field("z_dir_level", head_word.z_dir_level, m_data.z_dir_level);
                    compare_field("x_coord", head_word.x_coord, m_data.x_coord);
                    compare_field("y_coord", head_word.y_coord, m_data.y_coord);
                    compare_field("z_coord", head_word.z_coord, m_data.z_coord);
                    compare_field("homed", head_word.homed, m_data.homed);
                    compare_field("segment_done", head_word.segment_done,
                                  m_data.segment_done);
                end
                results_seen++;
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_hold = rx_burst ? 0 : $urandom_range(0, 4);
                // back up the pipeline once so the input side has to stall
                if (results_seen == HOLD_AT)
                    rx_hold = LONG_HOLD;
            end
            if (rx_hold != 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        in_word_t          w;
        int unsigned       tc;
        int                n;
        logic [CNT_W-1:0]  xs;
        logic [CNT_W-1:0]  ys;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;

        motion            = '0;
        motion.seg_dirs   = 2'b11;
        motion.seg_done   = 1'b1;

        // idle, cut and lower with nothing to do, straight out of reset
        directed_rows.push_back('{make_word(OP_TICK, MODE_IDLE, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000000, 0, 0, 0, 1'b0, 1'b1)});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b111, 2'b11, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000000, 0, 0, 0, 1'b0, 1'b1)});
        directed_rows.push_back('{make_word(OP_TICK, MODE_LOWER, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000000, 0, 0, 0, 1'b0, 1'b1)});
        directed_rows.push_back('{make_word(OP_ZSET, MODE_HOME, 3'b000, 2'b00,
                                            0, 0, 0, 0, 16'hFFFF),
                                  1'b1, fixed_out(6'b000000, 0, 0, 16'hFFFF, 1'b0, 1'b1)});
        directed_rows.push_back('{make_word(OP_TICK, MODE_LOWER, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000010, 0, 0, 16'hFFFE, 1'b0, 1'b1)});
        // full-scale segment, counter-clockwise both axes
        directed_rows.push_back('{make_word(OP_LOAD, MODE_IDLE, 3'b000, 2'b00,
                                            16'hFFFF, 16'hFFFF, 16'hFFFF, 2'b00, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_IDLE, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        // x count above tick count gets clamped; busy hides pulses on each axis
        directed_rows.push_back('{make_word(OP_LOAD, MODE_CUT, 3'b000, 2'b00,
                                            3, 1, 2, 2'b11, 0), 1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b10, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b01, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        // zero-length segment
        directed_rows.push_back('{make_word(OP_LOAD, MODE_CUT, 3'b000, 2'b00,
                                            5, 0, 0, 2'b10, 0), 1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        // segment interrupted by a homing tick
        directed_rows.push_back('{make_word(OP_LOAD, MODE_LOWER, 3'b000, 2'b00,
                                            1, 2, 3, 2'b01, 0), 1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_HOME, 3'b111, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_CUT, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        // homing: x and y open with x busy, then all closed, then already homed
        directed_rows.push_back('{make_word(OP_TICK, MODE_HOME, 3'b110, 2'b10, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_HOME, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000000, 0, 0, 0, 1'b1, 1'b1)});
        directed_rows.push_back('{make_word(OP_TICK, MODE_HOME, 3'b111, 2'b00, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000000, 0, 0, 0, 1'b1, 1'b1)});
        directed_rows.push_back('{make_word(OP_HOME, MODE_CUT, 3'b111, 2'b11, 0, 0, 0, 0, 0),
                                  1'b1, fixed_out(6'b000000, 0, 0, 0, 1'b0, 1'b1)});
        directed_rows.push_back('{make_word(OP_ZSET, MODE_IDLE, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{make_word(OP_TICK, MODE_LOWER, 3'b000, 2'b00, 0, 0, 0, 0, 0),
                                  1'b0, '0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);

        while (words_sent < directed_rows.size() + RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // load a segment and run it through (long ones only in part), now and then breaking out of cut
                    if ($urandom_range(0, 9) == 0)
                        tc = $urandom_range(0, 16'hFFFF);
                    else if ($urandom_range(0, 15) == 0)
                        tc = 0;
                    else
                        tc = $urandom_range(1, 12);
                    xs = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom) :
                                                      CNT_W'($urandom_range(0, tc + 2));
                    ys = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom) :
                                                      CNT_W'($urandom_range(0, tc + 2));
                    w = rand_word();
                    w.op = OP_LOAD;
                    w.tick_count = CNT_W'(tc);
                    w.x_steps = xs;
                    w.y_steps = ys;
                    send_word(w, 1'b0, '0);
                    n = ((tc > 12) ? 12 : tc) + $urandom_range(0, 2);
                    repeat (n) begin
                        w = rand_word();
                        w.op = OP_TICK;
                        if ($urandom_range(0, 7) != 0)
                            w.mode = MODE_CUT;
                        send_word(w, 1'b0, '0);
                    end
                end
                4, 5: begin
                    if ($urandom_range(0, 4) != 0) begin
                        w = rand_word();
                        w.op = OP_HOME;
                        send_word(w, 1'b0, '0);
                    end
                    repeat ($urandom_range(0, 3)) begin
                        w = rand_word();
                        w.op = OP_TICK;
                        w.mode = MODE_HOME;
                        w.z_limit_open = 1'b1;
                        send_word(w, 1'b0, '0);
                    end
                    repeat ($urandom_range(0, 4)) begin
                        w = rand_word();
                        w.op = OP_TICK;
                        w.mode = MODE_HOME;
                        w.z_limit_open = 1'b0;
                        {w.x_limit_open, w.y_limit_open} = 2'($urandom_range(1, 3));
                        send_word(w, 1'b0, '0);
                    end
                    w = rand_word();
                    w.op = OP_TICK;
                    w.mode = MODE_HOME;
                    {w.x_limit_open, w.y_limit_open, w.z_limit_open} = 3'b000;
                    send_word(w, 1'b0, '0);
                end
                6: begin
                    w = rand_word();
                    w.op = OP_ZSET;
                    if ($urandom_range(0, 3) != 0)
                        w.z_depth = CNT_W'($urandom_range(0, 6));
                    send_word(w, 1'b0, '0);
                    repeat ($urandom_range(1, 8)) begin
                        w = rand_word();
                        w.op = OP_TICK;
                        w.mode = MODE_LOWER;
                        send_word(w, 1'b0, '0);
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_word(rand_word(), 1'b0, '0);
                end
            endcase
        end
        s_valid <= 1'b0;

        wait (expected_words.size() == 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
